/* rtl/core/hbq_pkg.sv */
// Package: shared types, constants and helper functions of the half-block cell colour quantiser
`default_nettype none

package hbq_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned INDEX_W = 8;

    // Sum of three channels fits in 10 bits (max 765)
    localparam int unsigned SUM_W   = 10;

    // Gray test tolerance on every pairwise channel difference
    localparam int unsigned GRAY_TOL = 9;

    // Gray level bounds, expressed on the channel sum (level = sum / 3)
    localparam int unsigned GRAY_LEVEL_LOW  = 8;
    localparam int unsigned GRAY_LEVEL_HIGH = 247;
    localparam int unsigned GRAY_SUM_LOW    = 3 * GRAY_LEVEL_LOW;
    localparam int unsigned GRAY_SUM_HIGH   = 3 * (GRAY_LEVEL_HIGH + 1);

    // Gray ramp step = (level - 8) * 24 / 240 = (sum - 24) / 30
    localparam int unsigned RAMP_DIV     = 3 * (240 / 24);
    localparam int unsigned RAMP_SHIFT   = 15;
    localparam int unsigned RAMP_RECIP   = ((1 << RAMP_SHIFT) + RAMP_DIV - 1) / RAMP_DIV;
    localparam int unsigned RAMP_PROD_W  = SUM_W + 11;
    localparam int unsigned RAMP_STEP_W  = 5;

    // Palette indexes
    localparam logic [INDEX_W-1:0] CUBE_BLACK = 8'd16;
    localparam logic [INDEX_W-1:0] CUBE_WHITE = 8'd231;
    localparam logic [INDEX_W-1:0] GRAY_BASE  = 8'd232;

    // Cube level = channel * 5 / 255 = channel / 51
    localparam int unsigned CUBE_STEP = 255 / 5;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } color_t;

    typedef logic [2:0] cube_level_t;

    // Scale one channel onto the six cube levels by threshold compare
    function automatic cube_level_t cube_level(input chan_t c);
        cube_level_t lvl;
        lvl = 3'd0;
        if (c >= CHAN_W'(5 * CUBE_STEP))
            lvl = 3'd5;
        else if (c >= CHAN_W'(4 * CUBE_STEP))
            lvl = 3'd4;
        else if (c >= CHAN_W'(3 * CUBE_STEP))
            lvl = 3'd3;
        else if (c >= CHAN_W'(2 * CUBE_STEP))
            lvl = 3'd2;
        else if (c >= CHAN_W'(CUBE_STEP))
            lvl = 3'd1;
        return lvl;
    endfunction

    // True when two channels differ by no more than the gray tolerance
    function automatic logic chan_close(input chan_t a, input chan_t b);
        chan_t d;
        d = (a >= b) ? (a - b) : (b - a);
        return d <= CHAN_W'(GRAY_TOL);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/half_block_cell_color_quantizer.sv */
// Top level: registered half-block cell colour quantiser with valid/stall channels
// Each accepted cell is captured in the input register, then mapped into the output register once it is free.
// Throughput: one cell per cycle; input stalls only while both registers hold a stalled result.
// The mapping is combinational between the two registers: one reciprocal multiply per half and compares.
// Reset (rst_n, asynchronous, active low) empties both stages; payload registers are not reset.
`default_nettype none

module half_block_cell_color_quantizer (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [hbq_pkg::CHAN_W-1:0]       top_red,
    input  wire  [hbq_pkg::CHAN_W-1:0]       top_green,
    input  wire  [hbq_pkg::CHAN_W-1:0]       top_blue,
    input  wire  [hbq_pkg::CHAN_W-1:0]       bottom_red,
    input  wire  [hbq_pkg::CHAN_W-1:0]       bottom_green,
    input  wire  [hbq_pkg::CHAN_W-1:0]       bottom_blue,
    input  wire                              bottom_present,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [hbq_pkg::INDEX_W-1:0]      fg_index,
    output logic [hbq_pkg::INDEX_W-1:0]      bg_index
);

    logic                           in_valid_reg;
    logic                           in_valid_next;
    hbq_pkg::color_t                top_reg;
    hbq_pkg::color_t                bottom_reg;
    logic                           present_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [hbq_pkg::INDEX_W-1:0]    fg_reg;
    logic [hbq_pkg::INDEX_W-1:0]    bg_reg;
    logic                           in_take;
    logic                           out_free;
    logic                           out_load;
    hbq_pkg::color_t                bottom_color;
    logic [hbq_pkg::INDEX_W-1:0]    fg_next;
    logic [hbq_pkg::INDEX_W-1:0]    bg_next;

    // Handshake control
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_load       = in_valid_reg && out_free;
    assign in_stall       = in_valid_reg && !out_free;
    assign in_take        = in_valid && !in_stall;
    assign in_valid_next  = in_take || (in_valid_reg && !out_free);
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Hold stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transfer
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            top_reg     <= '{red: top_red, green: top_green, blue: top_blue};
            bottom_reg  <= '{red: bottom_red, green: bottom_green, blue: bottom_blue};
            present_reg <= bottom_present;
        end
    end

    // Treat a missing bottom sample as black
    assign bottom_color = present_reg ? bottom_reg : '0;

    hbq_color_map u_fg_map (
        .color (top_reg),
        .index (fg_next)
    );

    hbq_color_map u_bg_map (
        .color (bottom_color),
        .index (bg_next)
    );

    // Advance results into the output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fg_index  = fg_reg;
    assign bg_index  = bg_reg;

    // Stall only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while a stage is free");

    // An accepted transfer always lands in the input register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted transfer lost");

    // Output drains when taken and nothing follows
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !in_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after transfer");

    // A missing bottom sample gives cube black as background
    a_absent_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !present_reg) |=> (bg_reg == hbq_pkg::CUBE_BLACK))
        else $error("absent bottom sample not black");

    // Results never fall in the system colour range
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((fg_reg >= hbq_pkg::CUBE_BLACK) && (bg_reg >= hbq_pkg::CUBE_BLACK)))
        else $error("palette index below cube base");

endmodule

`default_nettype wire

/* rtl/core/hbq_color_map.sv */
// Colour map: one RGB888 colour to an xterm 256-colour palette index
`default_nettype none

module hbq_color_map (
    input  wire hbq_pkg::color_t               color,
    output logic [hbq_pkg::INDEX_W-1:0]        index
);

    logic                                   is_gray;
    logic [hbq_pkg::SUM_W-1:0]              chan_sum;
    logic [hbq_pkg::SUM_W-1:0]              ramp_offset;
    logic [hbq_pkg::RAMP_PROD_W-1:0]        ramp_prod;
    logic [hbq_pkg::RAMP_STEP_W-1:0]        ramp_step;
    hbq_pkg::cube_level_t                   lvl_r;
    hbq_pkg::cube_level_t                   lvl_g;
    hbq_pkg::cube_level_t                   lvl_b;
    logic [hbq_pkg::INDEX_W-1:0]            cube_index;
    logic [hbq_pkg::INDEX_W-1:0]            gray_index;

    // Detect near-gray colours
    assign is_gray = hbq_pkg::chan_close(color.red, color.green)
                   && hbq_pkg::chan_close(color.green, color.blue)
                   && hbq_pkg::chan_close(color.blue, color.red);

    // Sum channels; the gray level is this sum divided by three
    assign chan_sum = hbq_pkg::SUM_W'(color.red) + hbq_pkg::SUM_W'(color.green)
                    + hbq_pkg::SUM_W'(color.blue);

    // Ramp step by reciprocal multiply, exact over the mid-gray range
    assign ramp_offset = chan_sum - hbq_pkg::SUM_W'(hbq_pkg::GRAY_SUM_LOW);
    assign ramp_prod   = hbq_pkg::RAMP_PROD_W'(ramp_offset)
                       * hbq_pkg::RAMP_PROD_W'(hbq_pkg::RAMP_RECIP);
    assign ramp_step   = ramp_prod[hbq_pkg::RAMP_SHIFT +: hbq_pkg::RAMP_STEP_W];

    // Pick the gray ramp entry or clamp to cube black and white
    always_comb
    begin
        if (chan_sum < hbq_pkg::SUM_W'(hbq_pkg::GRAY_SUM_LOW))
            gray_index = hbq_pkg::CUBE_BLACK;
        else if (chan_sum >= hbq_pkg::SUM_W'(hbq_pkg::GRAY_SUM_HIGH))
            gray_index = hbq_pkg::CUBE_WHITE;
        else
            gray_index = hbq_pkg::GRAY_BASE + hbq_pkg::INDEX_W'(ramp_step);
    end

    // Build the 6x6x6 cube index
    assign lvl_r = hbq_pkg::cube_level(color.red);
    assign lvl_g = hbq_pkg::cube_level(color.green);
    assign lvl_b = hbq_pkg::cube_level(color.blue);

    assign cube_index = hbq_pkg::CUBE_BLACK
                      + hbq_pkg::INDEX_W'(lvl_r) * hbq_pkg::INDEX_W'(36)
                      + hbq_pkg::INDEX_W'(lvl_g) * hbq_pkg::INDEX_W'(6)
                      + hbq_pkg::INDEX_W'(lvl_b);

    assign index = is_gray ? gray_index : cube_index;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the half-block cell colour quantiser: directed table, random cells
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CELLS  = 1500;
    localparam int QUIET_CELLS   = 200;
    localparam int PHASE_CELLS   = 250;
    localparam int PRESSURE_CELL = 700;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int IDLE_PCT [4]  = '{0, 5, 25, 60};

    // Grey test spread on channel differences; ramp limits on the mean level of the three channels
    localparam int GREY_SPREAD = 9;
    localparam int GREY_DARK   = 8;
    localparam int GREY_LIGHT  = 247;

    typedef struct packed {
        hbq_pkg::color_t top;
        hbq_pkg::color_t bot;
        logic            present;
    } cell_t;

    typedef struct packed {
        logic [hbq_pkg::INDEX_W-1:0] fg;
        logic [hbq_pkg::INDEX_W-1:0] bg;
    } cell_indices_t;

    typedef struct packed {
        hbq_pkg::color_t             top;
        hbq_pkg::color_t             bot;
        logic                        present;
        logic                        known;
        logic [hbq_pkg::INDEX_W-1:0] fg;
        logic [hbq_pkg::INDEX_W-1:0] bg;
    } cell_row_t;

    // Directed cells; rows marked known carry indices read straight off the mapping
    localparam cell_row_t CELL_TABLE [19] = '{
        '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, 1'b1, 1'b1, 8'd16, 8'd16},
        '{'{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, 1'b1, 1'b1, 8'd231, 8'd231},
        '{'{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, 1'b1, 1'b1, 8'd196, 8'd46},
        '{'{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0}, 1'b1, 1'b1, 8'd21, 8'd226},
        '{'{8'd7, 8'd7, 8'd7}, '{8'd8, 8'd8, 8'd8}, 1'b1, 1'b1, 8'd16, 8'd232},
        '{'{8'd247, 8'd247, 8'd247}, '{8'd248, 8'd248, 8'd248}, 1'b1, 1'b1, 8'd255, 8'd231},
        '{'{8'd128, 8'd128, 8'd128}, '{8'd200, 8'd50, 8'd10}, 1'b0, 1'b1, 8'd244, 8'd16},
        '{'{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, 1'b0, 1'b1, 8'd231, 8'd16},
        '{'{8'd100, 8'd109, 8'd100}, '{8'd100, 8'd110, 8'd100}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd0, 8'd9, 8'd0}, '{8'd0, 8'd10, 8'd0}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd0, 8'd9, 8'd18}, '{8'd246, 8'd255, 8'd250}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd50, 8'd51, 8'd102}, '{8'd101, 8'd152, 8'd153}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd203, 8'd204, 8'd254}, '{8'd1, 8'd254, 8'd203}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd204, 8'd153, 8'd102}, '{8'd51, 8'd0, 8'd255}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd170, 8'd85, 8'd0}, '{8'd0, 8'd85, 8'd170}, 1'b0, 1'b0, 8'd0, 8'd0},
        '{'{8'd30, 8'd30, 8'd39}, '{8'd239, 8'd230, 8'd230}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd23, 8'd24, 8'd25}, '{8'd24, 8'd24, 8'd24}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd170, 8'd170, 8'd170}, '{8'd85, 8'd85, 8'd85}, 1'b1, 1'b0, 8'd0, 8'd0},
        '{'{8'd85, 8'd170, 8'd85}, '{8'd170, 8'd85, 8'd170}, 1'b1, 1'b0, 8'd0, 8'd0}
    };

    logic                        clk            = 1'b0;
    logic                        rst_n          = 1'b0;
    logic                        in_valid       = 1'b0;
    logic                        in_stall;
    hbq_pkg::color_t             top_pix        = '0;
    hbq_pkg::color_t             bot_pix        = '0;
    logic                        bottom_present = 1'b0;
    logic                        out_valid;
    logic                        out_stall      = 1'b0;
    logic [hbq_pkg::INDEX_W-1:0] fg_index;
    logic [hbq_pkg::INDEX_W-1:0] bg_index;

    cell_indices_t expected_indices [$];
    int            cells_sent    = 0;
    int            cells_checked = 0;
    int            mismatches    = 0;
    int            gap_pct       = 25;
    int            stall_pct     = 25;
    logic          quiet         = 1'b0;
    int            idle_cycles   = 0;

    half_block_cell_color_quantizer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .top_red        (top_pix.red),
        .top_green      (top_pix.green),
        .top_blue       (top_pix.blue),
        .bottom_red     (bot_pix.red),
        .bottom_green   (bot_pix.green),
        .bottom_blue    (bot_pix.blue),
        .bottom_present (bottom_present),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fg_index       (fg_index),
        .bg_index       (bg_index)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Map one RGB sample to its palette index: grey ramp when near grey, else the colour cube
    function automatic logic [hbq_pkg::INDEX_W-1:0] palette_index(input hbq_pkg::color_t c);
        int   r;
        int   g;
        int   b;
        int   level;
        int   idx;
        logic near_grey;
        r = c.red;
        g = c.green;
        b = c.blue;
        near_grey = (r - g <= GREY_SPREAD) && (g - r <= GREY_SPREAD)
                 && (g - b <= GREY_SPREAD) && (b - g <= GREY_SPREAD)
                 && (b - r <= GREY_SPREAD) && (r - b <= GREY_SPREAD);
        if (near_grey)
        begin
            level = (r + g + b) / 3;
            if (level < GREY_DARK)
                idx = 16;
            else if (level > GREY_LIGHT)
                idx = 231;
            else
                idx = 232 + ((level - GREY_DARK) * 24) / 240;
        end
        else
        begin
            idx = 16 + 36 * ((r * 5) / 255) + 6 * ((g * 5) / 255) + (b * 5) / 255;
        end
        return idx[hbq_pkg::INDEX_W-1:0];
    endfunction

    // Blacken a missing lower sample, then index both halves
    function automatic cell_indices_t predict_indices(input cell_t c);
        hbq_pkg::color_t lower;
        cell_indices_t   res;
        lower  = c.present ? c.bot : '0;
        res.fg = palette_index(c.top);
        res.bg = palette_index(lower);
        return res;
    endfunction

    function automatic hbq_pkg::chan_t near_channel(input int centre, input int spread);
        int v;
        v = centre - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[hbq_pkg::CHAN_W-1:0];
    endfunction

    // Mix uniform colours with near-grey samples and colours on cube boundaries
    function automatic hbq_pkg::color_t random_colour();
        hbq_pkg::color_t c;
        int              base;
        case ($urandom_range(0, 3))
            0:
            begin
                c.red   = hbq_pkg::chan_t'($urandom_range(0, 255));
                c.green = hbq_pkg::chan_t'($urandom_range(0, 255));
                c.blue  = hbq_pkg::chan_t'($urandom_range(0, 255));
            end
            1, 2:
            begin
                if ($urandom_range(0, 1) == 0)
                    base = $urandom_range(0, 255);
                else if ($urandom_range(0, 1) == 0)
                    base = $urandom_range(0, 20);
                else
                    base = $urandom_range(235, 255);
                c.red   = near_channel(base, 10);
                c.green = near_channel(base, 10);
                c.blue  = near_channel(base, 10);
            end
            default:
            begin
                c.red   = near_channel(51 * int'($urandom_range(0, 5)), 2);
                c.green = near_channel(51 * int'($urandom_range(0, 5)), 2);
                c.blue  = near_channel(51 * int'($urandom_range(0, 5)), 2);
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Offer one cell, hold it until the transfer, then record its expected indices
    task automatic send_cell(input cell_t c, input logic known, input cell_indices_t typed);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        top_pix        <= c.top;
        bot_pix        <= c.bot;
        bottom_present <= c.present;
        do
            @(posedge clk);
        while (in_stall);
        expected_indices.push_back(known ? typed : predict_indices(c));
        cells_sent++;
    endtask

    // Compare each result transfer with the oldest expected pair
    always @(posedge clk)
    begin : check_result
        cell_indices_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_indices.size() == 0)
            begin
                report_mismatch($sformatf("result fg=%0d bg=%0d with no cell outstanding",
                                          fg_index, bg_index));
            end
            else
            begin
                want = expected_indices.pop_front();
                if (fg_index !== want.fg)
                    report_mismatch($sformatf("fg_index %0d, expected %0d", fg_index, want.fg));
                if (bg_index !== want.bg)
                    report_mismatch($sformatf("bg_index %0d, expected %0d", bg_index, want.bg));
                cells_checked++;
            end
        end
    end

    // Stall the result channel in random bursts; none once the run goes quiet
    initial
    begin : drive_out_stall
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (quiet)
            begin
                out_stall  <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(0, 13);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        cell_t         c;
        cell_indices_t typed;
        int            n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (CELL_TABLE[i])
        begin
            c.top     = CELL_TABLE[i].top;
            c.bot     = CELL_TABLE[i].bot;
            c.present = CELL_TABLE[i].present;
            typed.fg  = CELL_TABLE[i].fg;
            typed.bg  = CELL_TABLE[i].bg;
            send_cell(c, CELL_TABLE[i].known, typed);
        end

        // Random cells in phases of varying idle pressure
        for (n = 0; n < RANDOM_CELLS; n++)
        begin
            if (n % PHASE_CELLS == 0)
            begin
                gap_pct   = IDLE_PCT[$urandom_range(0, 3)];
                stall_pct <= IDLE_PCT[$urandom_range(0, 3)];
            end
            if (n == RANDOM_CELLS - QUIET_CELLS)
                quiet <= 1'b1;
            if (n == PRESSURE_CELL)
            begin
                // Hold off until every outstanding result has drained
                in_valid <= 1'b0;
                wait (cells_checked == cells_sent);
                @(posedge clk);
            end
            c.top     = random_colour();
            c.bot     = random_colour();
            c.present = ($urandom_range(0, 3) != 0);
            send_cell(c, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain, then keep watching for any stray result before the verdict
        wait (cells_checked == cells_sent);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
